FILE: sv/fmc_pkg.sv
// Shared types, constants and the mode decode for the light mode controller.
`default_nettype none

package fmc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SHORT_THRESHOLD  = 3'd0,
        CFG_MEDIUM_THRESHOLD = 3'd1,
        CFG_LOW_BATTERY      = 3'd2,
        CFG_MEMORY_ENABLE    = 3'd3,
        CFG_TURBO_LIMIT      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_POWER_ON = 2'd0,
        OP_TICK     = 2'd1,
        OP_BATTERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PAT_SOLID  = 2'd0,
        PAT_STROBE = 2'd1,
        PAT_BIKE   = 2'd2,
        PAT_BATT   = 2'd3
    } pattern_t;

    // Low two bits of a blinky kind are its pattern code
    typedef enum logic [2:0] {
        KIND_SOLID  = 3'd0,
        KIND_STROBE = 3'd1,
        KIND_BIKE   = 3'd2,
        KIND_BATT   = 3'd3,
        KIND_TURBO  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] short_threshold;
        logic [7:0] medium_threshold;
        logic [7:0] low_battery_level;
        logic       memory_enable;
        logic [7:0] turbo_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        short_threshold:   8'd190,
        medium_threshold:  8'd94,
        low_battery_level: 8'd125,
        memory_enable:     1'b0,
        turbo_limit:       8'd90
    };

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] cap_level;
        logic [7:0] battery_level;
    } item_t;

    typedef struct packed {
        logic [3:0] mode_index;
        logic [7:0] main_level;
        logic [7:0] alt_level;
        logic       fast_pwm;
        logic [1:0] pattern;
        logic       save_request;
        logic       shutdown;
    } result_t;

    typedef struct packed {
        logic [7:0] main_level;
        logic [7:0] alt_level;
        logic       fast_pwm;
        logic [1:0] pattern;
        logic       turbo;
    } mode_look_t;

    // Low battery in any hidden mode drops to this solid mode
    localparam logic [3:0] MODE_LOW_BATT_HIDDEN = 4'd2;

    localparam logic [7:0] MAIN_LEVELS [16] = '{
        8'd0, 8'd0, 8'd0, 8'd7, 8'd56, 8'd137, 8'd255, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam logic [7:0] ALT_LEVELS [16] = '{
        8'd3, 8'd20, 8'd110, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // Bit n set: solid mode n runs fast PWM
    localparam logic [15:0] FAST_PWM_MASK = 16'b0000_0000_0011_1110;

    localparam kind_t HIDDEN_KINDS [8] = '{
        KIND_BIKE, KIND_BATT, KIND_STROBE, KIND_TURBO,
        KIND_TURBO, KIND_TURBO, KIND_TURBO, KIND_TURBO
    };

    function automatic mode_look_t describe_mode(logic [3:0] mode, logic [3:0] solid_n);
        mode_look_t look;
        kind_t      kind;
        logic [3:0] hidden_off;
        look       = '0;
        kind       = KIND_SOLID;
        hidden_off = mode - solid_n;
        if (mode < solid_n)
        begin
            look.main_level = MAIN_LEVELS[mode];
            look.alt_level  = ALT_LEVELS[mode];
            look.fast_pwm   = FAST_PWM_MASK[mode];
        end
        else
        begin
            kind = HIDDEN_KINDS[hidden_off[2:0]];
            if (kind == KIND_TURBO)
                look.main_level = 8'hFF;
            else
                look.pattern = kind[1:0];
        end
        if (look.main_level == 8'd0 && look.alt_level == 8'd0)
            look.fast_pwm = 1'b0;
        look.turbo = (look.pattern == PAT_SOLID) && (look.main_level == 8'hFF);
        return look;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fmc_if.sv
// Request and result channel interfaces of the light mode controller.
`default_nettype none

interface fmc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] cap_level;
    logic [7:0] battery_level;

    modport source (output valid, output op, output cap_level, output battery_level,
                    input ready);
    modport sink   (input valid, input op, input cap_level, input battery_level,
                    output ready);
endinterface

interface fmc_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] mode_index;
    logic [7:0] main_level;
    logic [7:0] alt_level;
    logic       fast_pwm;
    logic [1:0] pattern;
    logic       save_request;
    logic       shutdown;

    modport source (output valid, output mode_index, output main_level, output alt_level,
                    output fast_pwm, output pattern, output save_request,
                    output shutdown, input ready);
    modport sink   (input valid, input mode_index, input main_level, input alt_level,
                    input fast_pwm, input pattern, input save_request,
                    input shutdown, output ready);
endinterface

`default_nettype wire

FILE: sv/fmc_cfg_regs.sv
// Configuration register file, write only.
`default_nettype none

module fmc_cfg_regs
    import fmc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHORT_THRESHOLD:  cfg_reg.short_threshold   <= cfg_wdata;
                CFG_MEDIUM_THRESHOLD: cfg_reg.medium_threshold  <= cfg_wdata;
                CFG_LOW_BATTERY:      cfg_reg.low_battery_level <= cfg_wdata;
                CFG_MEMORY_ENABLE:    cfg_reg.memory_enable     <= cfg_wdata[0];
                CFG_TURBO_LIMIT:      cfg_reg.turbo_limit       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/fmc_mode_core.sv
// Mode state, counters and the single-pass next-mode and result decode.
`default_nettype none

module fmc_mode_core
    import fmc_pkg::*;
#(
    parameter int SOLID_COUNT        = 7,
    parameter int HIDDEN_COUNT       = 4,
    parameter int LOW_SAMPLES_NEEDED = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic step,
    input  item_t     item,
    output result_t   res
);

    localparam logic [3:0] SOLID_N        = 4'(SOLID_COUNT);
    localparam logic [3:0] LAST_MODE      = 4'(SOLID_COUNT + HIDDEN_COUNT - 1);
    localparam logic [3:0] TURBO_FALLBACK = 4'(SOLID_COUNT - 2);
    localparam logic [3:0] LOW_N          = 4'(LOW_SAMPLES_NEEDED);

    logic [3:0] mode_reg, mode_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [3:0] low_sample_count_reg, low_sample_count_next;

    mode_look_t cur_look, new_look;
    logic [4:0] mode_inc;
    logic [7:0] tick_inc;
    logic [3:0] low_cnt;
    logic       save;
    logic       shut;

    assign cur_look = describe_mode(mode_reg, SOLID_N);
    assign mode_inc = {1'b0, mode_reg} + 5'd1;
    assign tick_inc = tick_count_reg + 8'd1;

    always_comb
    begin
        mode_next             = mode_reg;
        tick_count_next       = tick_count_reg;
        low_sample_count_next = low_sample_count_reg;
        low_cnt               = '0;
        save                  = 1'b0;
        shut                  = 1'b0;
        case (item.op)
            OP_POWER_ON:
            begin
                tick_count_next       = '0;
                low_sample_count_next = '0;
                save                  = 1'b1;
                if (item.cap_level > cfg.short_threshold)
                begin
                    mode_next = (mode_inc >= {1'b0, SOLID_N}) ? 4'd0 : mode_inc[3:0];
                end
                else if (item.cap_level > cfg.medium_threshold)
                begin
                    // first hidden mode returns to 0, mode 0 wraps to last hidden
                    if (mode_reg == SOLID_N)
                        mode_next = 4'd0;
                    else if (mode_reg != 4'd0)
                        mode_next = mode_reg - 4'd1;
                    else
                        mode_next = LAST_MODE;
                end
                else if (!cfg.memory_enable)
                begin
                    mode_next = 4'd0;
                end
            end
            OP_TICK:
            begin
                if (cur_look.pattern == PAT_SOLID)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc > cfg.turbo_limit && cur_look.turbo)
                    begin
                        mode_next = TURBO_FALLBACK;
                        save      = 1'b1;
                    end
                end
            end
            OP_BATTERY:
            begin
                low_cnt = (item.battery_level < cfg.low_battery_level)
                          ? low_sample_count_reg + 4'd1 : 4'd0;
                low_sample_count_next = low_cnt;
                if (low_cnt >= LOW_N)
                begin
                    if (mode_reg >= SOLID_N)
                        mode_next = MODE_LOW_BATT_HIDDEN;
                    else if (mode_reg != 4'd0)
                        mode_next = mode_reg - 4'd1;
                    else
                        shut = 1'b1;
                    save                  = 1'b1;
                    low_sample_count_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign new_look = describe_mode(mode_next, SOLID_N);

    always_comb
    begin
        res.mode_index   = mode_next;
        res.main_level   = shut ? 8'd0 : new_look.main_level;
        res.alt_level    = shut ? 8'd0 : new_look.alt_level;
        res.fast_pwm     = shut ? 1'b0 : new_look.fast_pwm;
        res.pattern      = shut ? PAT_SOLID : new_look.pattern;
        res.save_request = save;
        res.shutdown     = shut;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg             <= '0;
            tick_count_reg       <= '0;
            low_sample_count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg             <= mode_next;
            tick_count_reg       <= tick_count_next;
            low_sample_count_reg <= low_sample_count_next;
        end
    end

    a_mode_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= LAST_MODE)
        else $error("mode beyond last hidden mode");

    a_low_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        low_sample_count_reg < LOW_N)
        else $error("low battery count not cleared at limit");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg) && $stable(tick_count_reg))
        else $error("state changed without a request");

endmodule

`default_nettype wire

FILE: sv/flashlight_mode_controller.sv
// Light mode controller top level: request register, mode core, result register.
//
// One request per clock cycle is taken while ready is high and each gives one
// result: the request is captured in an input register, the mode core decodes
// it against the mode and counter state in one pass and the result lands in
// the output register while the state is updated. A waiting result does not
// block the next request, which is held in the input register; only when both
// registers are full and the result is not taken does ready drop.
// Configuration writes take effect on the next cycle and should only be made
// while no request is in flight.
`default_nettype none

module flashlight_mode_controller
    import fmc_pkg::*;
#(
    parameter int SOLID_COUNT        = 7,
    parameter int HIDDEN_COUNT       = 4,
    parameter int LOW_SAMPLES_NEEDED = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    fmc_item_if.sink                    item,
    fmc_result_if.source                result
);

    cfg_t    cfg;
    result_t core_res;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic    advance;
    logic    accept;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign accept     = item.valid && item.ready;

    fmc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fmc_mode_core #(
        .SOLID_COUNT        (SOLID_COUNT),
        .HIDDEN_COUNT       (HIDDEN_COUNT),
        .LOW_SAMPLES_NEEDED (LOW_SAMPLES_NEEDED)
    ) u_mode_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .item  (in_item_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.op            <= item.op;
            in_item_reg.cap_level     <= item.cap_level;
            in_item_reg.battery_level <= item.battery_level;
        end
        if (advance)
            out_res_reg <= core_res;
    end

    assign result.valid        = out_valid_reg;
    assign result.mode_index   = out_res_reg.mode_index;
    assign result.main_level   = out_res_reg.main_level;
    assign result.alt_level    = out_res_reg.alt_level;
    assign result.fast_pwm     = out_res_reg.fast_pwm;
    assign result.pattern      = out_res_reg.pattern;
    assign result.save_request = out_res_reg.save_request;
    assign result.shutdown     = out_res_reg.shutdown;

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decoded request lost before output register");

    a_stalled_request_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending request dropped or changed while stalled");

    a_shutdown_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.shutdown |->
            out_res_reg.mode_index == 4'd0 && out_res_reg.save_request
            && out_res_reg.main_level == 8'd0 && out_res_reg.alt_level == 8'd0)
        else $error("shutdown result not dark at mode 0");

endmodule

`default_nettype wire

FILE: tb/fmc_mode_checker.sv
// Checker for the light mode controller: tracks registers, predicts and compares results.
`timescale 1ns / 100ps

module fmc_mode_checker
    import fmc_pkg::*;
#(
    parameter int SOLID_COUNT        = 7,
    parameter int HIDDEN_COUNT       = 4,
    parameter int LOW_SAMPLES_NEEDED = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    fmc_item_if                    req_ch,
    fmc_result_if                  res_ch,
    output int                     failures,
    output int                     pending,
    output int                     checked,
    output int                     shutdowns
);

    localparam int REPORT_LIMIT = 10;

    // Duties of the first seven solid modes; any further solid mode is dark
    localparam logic [7:0] MAIN_DUTY [7] = '{8'd0, 8'd0, 8'd0, 8'd7, 8'd56, 8'd137, 8'd255};
    localparam logic [7:0] ALT_DUTY  [7] = '{8'd3, 8'd20, 8'd110, 8'd255, 8'd255, 8'd255, 8'd0};
    localparam logic [6:0] FAST_SOLID    = 7'b011_1110;

    cfg_t       setting;
    logic [3:0] lamp_mode;
    logic [7:0] tick_count;
    logic [3:0] low_run;
    result_t    expected_lights [$];
    int         fail_total;
    int         result_total;
    int         shut_total;

    function automatic result_t light_for_mode(input logic [3:0] m);
        result_t    r;
        logic [3:0] hidden_pos;
        r          = '0;
        r.mode_index = m;
        hidden_pos = m - 4'(SOLID_COUNT);
        if (int'(m) < SOLID_COUNT)
        begin
            if (m < 4'd7)
            begin
                r.main_level = MAIN_DUTY[m[2:0]];
                r.alt_level  = ALT_DUTY[m[2:0]];
                r.fast_pwm   = FAST_SOLID[m[2:0]];
            end
        end
        else
        begin
            // hidden order: biking strobe, battery check, tactical strobe, then turbo
            case (hidden_pos[2:0])
                3'd0:    r.pattern = PAT_BIKE;
                3'd1:    r.pattern = PAT_BATT;
                3'd2:    r.pattern = PAT_STROBE;
                default: r.main_level = 8'hFF;
            endcase
        end
        if (r.main_level == 8'd0 && r.alt_level == 8'd0)
            r.fast_pwm = 1'b0;
        return r;
    endfunction

    function automatic string light_text(input result_t r);
        return $sformatf(
            "mode=%0d main=%0d alt=%0d fast=%0b pat=%0d save=%0b shut=%0b",
            r.mode_index, r.main_level, r.alt_level, r.fast_pwm, r.pattern,
            r.save_request, r.shutdown);
    endfunction

    task automatic predict_light(input logic [1:0] op, input logic [7:0] cap,
                                 input logic [7:0] batt, output result_t r);
        result_t look;
        logic    in_turbo;
        logic    save;
        logic    shut;
        int      bumped_mode;
        look     = light_for_mode(lamp_mode);
        in_turbo = (look.pattern == PAT_SOLID) && (look.main_level == 8'hFF);
        save     = 1'b0;
        shut     = 1'b0;
        case (op)
            OP_POWER_ON:
            begin
                tick_count = '0;
                low_run    = '0;
                if (cap > setting.short_threshold)
                begin
                    bumped_mode = int'(lamp_mode) + 1;
                    lamp_mode = (bumped_mode >= SOLID_COUNT) ? 4'd0 : 4'(bumped_mode);
                end
                else if (cap > setting.medium_threshold)
                begin
                    if (int'(lamp_mode) == SOLID_COUNT)
                        lamp_mode = 4'd0;
                    else if (lamp_mode != 4'd0)
                        lamp_mode = lamp_mode - 4'd1;
                    else
                        lamp_mode = 4'(SOLID_COUNT + HIDDEN_COUNT - 1);
                end
                else if (!setting.memory_enable)
                begin
                    lamp_mode = 4'd0;
                end
                save = 1'b1;
            end
            OP_TICK:
            begin
                // blinky modes do not count ticks
                if (look.pattern == PAT_SOLID)
                begin
                    tick_count = tick_count + 8'd1;
                    if (tick_count > setting.turbo_limit && in_turbo)
                    begin
                        lamp_mode = 4'(SOLID_COUNT - 2);
                        save      = 1'b1;
                    end
                end
            end
            OP_BATTERY:
            begin
                if (batt < setting.low_battery_level)
                    low_run = low_run + 4'd1;
                else
                    low_run = '0;
                if (int'(low_run) >= LOW_SAMPLES_NEEDED)
                begin
                    if (int'(lamp_mode) >= SOLID_COUNT)
                        lamp_mode = MODE_LOW_BATT_HIDDEN;
                    else if (lamp_mode != 4'd0)
                        lamp_mode = lamp_mode - 4'd1;
                    else
                        shut = 1'b1;
                    save    = 1'b1;
                    low_run = '0;
                end
            end
            default:
            begin
            end
        endcase
        r = light_for_mode(lamp_mode);
        if (shut)
        begin
            r.main_level = '0;
            r.alt_level  = '0;
            r.fast_pwm   = 1'b0;
            r.pattern    = PAT_SOLID;
        end
        r.save_request = save;
        r.shutdown     = shut;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            setting    = CFG_RESET;
            lamp_mode  = '0;
            tick_count = '0;
            low_run    = '0;
            expected_lights.delete();
            fail_total   = 0;
            result_total = 0;
            shut_total   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SHORT_THRESHOLD:  setting.short_threshold   = cfg_wdata;
                    CFG_MEDIUM_THRESHOLD: setting.medium_threshold  = cfg_wdata;
                    CFG_LOW_BATTERY:      setting.low_battery_level = cfg_wdata;
                    CFG_MEMORY_ENABLE:    setting.memory_enable     = cfg_wdata[0];
                    CFG_TURBO_LIMIT:      setting.turbo_limit       = cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.mode_index   = res_ch.mode_index;
                got.main_level   = res_ch.main_level;
                got.alt_level    = res_ch.alt_level;
                got.fast_pwm     = res_ch.fast_pwm;
                got.pattern      = res_ch.pattern;
                got.save_request = res_ch.save_request;
                got.shutdown     = res_ch.shutdown;
                if (expected_lights.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: result with no request waiting: %s",
                                 $realtime, light_text(got));
                end
                else
                begin
                    want = expected_lights.pop_front();
                    result_total++;
                    if (want.shutdown)
                        shut_total++;
                    if (got !== want)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                        begin
                            $display("%0t: result %0d differs: expected %s",
                                     $realtime, result_total, light_text(want));
                            $display("    actual %s", light_text(got));
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                predict_light(req_ch.op, req_ch.cap_level, req_ch.battery_level, want);
                expected_lights.push_back(want);
            end
        end
        failures  <= fail_total;
        pending   <= expected_lights.size();
        checked   <= result_total;
        shutdowns <= shut_total;
    end

endmodule

FILE: tb/flashlight_mode_controller_tb.sv
// Testbench top for the light mode controller: clock, reset, requests, settings, verdict.
`timescale 1ns / 100ps

module flashlight_mode_controller_tb;
    import fmc_pkg::*;

    localparam int SOLID_COUNT        = 7;
    localparam int HIDDEN_COUNT       = 4;
    localparam int LOW_SAMPLES_NEEDED = 8;
    localparam int HALF_PERIOD        = 10;
    localparam int RESET_CYCLES       = 7;
    localparam int MAX_GAP            = 11;
    localparam int IDLE_LIMIT         = 500;
    localparam int RANDOM_ITEMS       = 1350;
    localparam int PHASES             = 6;
    localparam int SETTLE_CYCLES      = 4;
    localparam int DRAIN_CYCLES       = 8;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    int                     failures;
    int                     pending;
    int                     checked;
    int                     shutdowns;
    int                     sent [4];
    int                     settings_used;
    bit                     calm;
    cfg_t                   setting;

    fmc_item_if   req_ch();
    fmc_result_if res_ch();

    flashlight_mode_controller #(
        .SOLID_COUNT        (SOLID_COUNT),
        .HIDDEN_COUNT       (HIDDEN_COUNT),
        .LOW_SAMPLES_NEEDED (LOW_SAMPLES_NEEDED)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (req_ch),
        .result    (res_ch)
    );

    fmc_mode_checker #(
        .SOLID_COUNT        (SOLID_COUNT),
        .HIDDEN_COUNT       (HIDDEN_COUNT),
        .LOW_SAMPLES_NEEDED (LOW_SAMPLES_NEEDED)
    ) mode_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_ch    (req_ch),
        .res_ch    (res_ch),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked),
        .shutdowns (shutdowns)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    task automatic send_request(input logic [1:0] op, input logic [7:0] cap,
                                input logic [7:0] batt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.cap_level     <= cap;
        req_ch.battery_level <= batt;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent[op]++;
    endtask

    // Stop requesting and wait until every result is back
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] short_thr, input logic [7:0] medium_thr,
                                 input logic [7:0] low_level, input logic mem_on,
                                 input logic [7:0] timeout);
        write_reg(CFG_SHORT_THRESHOLD, short_thr);
        write_reg(CFG_MEDIUM_THRESHOLD, medium_thr);
        write_reg(CFG_LOW_BATTERY, low_level);
        write_reg(CFG_MEMORY_ENABLE, {7'd0, mem_on});
        write_reg(CFG_TURBO_LIMIT, timeout);
        setting.short_threshold   = short_thr;
        setting.medium_threshold  = medium_thr;
        setting.low_battery_level = low_level;
        setting.memory_enable     = mem_on;
        setting.turbo_limit       = timeout;
        settings_used++;
    endtask

    function automatic logic [7:0] near_level(input logic [7:0] level);
        int v;
        v = int'(level) + $urandom_range(0, 2) - 1;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // Off-time readings cluster around the thresholds so both sides of each get hit
    function automatic logic [7:0] pick_cap();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0)
            return near_level(setting.short_threshold);
        if (k == 1)
            return near_level(setting.medium_threshold);
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_batt(input bit want_low);
        if (want_low && setting.low_battery_level != 8'd0)
            return 8'($urandom_range(0, int'(setting.low_battery_level) - 1));
        return 8'($urandom_range(int'(setting.low_battery_level), 255));
    endfunction

    // Single presses, tick runs and low-battery runs, with some plain noise
    task automatic run_random(input int quota);
        int done;
        int kind;
        int run_len;
        done = 0;
        while (done < quota)
        begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            kind = $urandom_range(0, 99);
            if (kind < 28)
            begin
                send_request(OP_POWER_ON, pick_cap(), 8'($urandom_range(0, 255)));
                done++;
            end
            else if (kind < 55)
            begin
                // now and then a run long enough to outlast the turbo timeout
                if ($urandom_range(0, 7) == 0)
                    run_len = int'(setting.turbo_limit) + $urandom_range(1, 3);
                else
                    run_len = $urandom_range(1, 12);
                repeat (run_len)
                    send_request(OP_TICK, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                done += run_len;
            end
            else if (kind < 85)
            begin
                run_len = $urandom_range(1, 11);
                repeat (run_len)
                    send_request(OP_BATTERY, 8'($urandom_range(0, 255)),
                                 pick_batt($urandom_range(0, 9) != 0));
                done += run_len;
            end
            else if (kind < 97)
            begin
                send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                done++;
            end
            else
            begin
                send_request(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                done++;
            end
        end
    endtask

    initial
    begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int         phase;
        logic [7:0] short_thr;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_SHORT_THRESHOLD;
        cfg_wdata            = '0;
        req_ch.valid         = 1'b0;
        req_ch.op            = OP_POWER_ON;
        req_ch.cap_level     = '0;
        req_ch.battery_level = '0;
        calm                 = 1'b0;
        setting              = CFG_RESET;
        settings_used        = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: every press class, the hidden modes and their wrap
        send_request(OP_UNUSED, 8'hFF, 8'h00);
        send_request(OP_TICK, 8'h00, 8'hFF);
        send_request(OP_POWER_ON, 8'd255, 8'h00);
        send_request(OP_POWER_ON, 8'd191, 8'h00);
        send_request(OP_POWER_ON, 8'd190, 8'h00);
        send_request(OP_POWER_ON, 8'd95, 8'h00);
        send_request(OP_POWER_ON, 8'd94, 8'h00);
        send_request(OP_POWER_ON, 8'd150, 8'h00);
        send_request(OP_POWER_ON, 8'd100, 8'h00);
        send_request(OP_TICK, 8'h00, 8'h00);
        send_request(OP_POWER_ON, 8'd100, 8'h00);
        send_request(OP_POWER_ON, 8'd100, 8'h00);
        send_request(OP_POWER_ON, 8'd100, 8'h00);
        send_request(OP_POWER_ON, 8'd150, 8'h00);
        send_request(OP_POWER_ON, 8'd255, 8'h00);
        send_request(OP_POWER_ON, 8'd150, 8'h00);
        // low battery while in a hidden mode
        repeat (LOW_SAMPLES_NEEDED) send_request(OP_BATTERY, 8'h00, 8'd124);

        // memory on, immediate turbo step-down, then shutdown from the lowest mode
        settle();
        apply_setting(8'd190, 8'd94, 8'd125, 1'b1, 8'd0);
        send_request(OP_POWER_ON, 8'd100, 8'h00);
        send_request(OP_POWER_ON, 8'd100, 8'h00);
        send_request(OP_POWER_ON, 8'd150, 8'h00);
        send_request(OP_TICK, 8'h00, 8'h00);
        send_request(OP_POWER_ON, 8'd0, 8'h00);
        send_request(OP_POWER_ON, 8'd255, 8'h00);
        send_request(OP_TICK, 8'h00, 8'h00);
        send_request(OP_POWER_ON, 8'd255, 8'h00);
        send_request(OP_POWER_ON, 8'd255, 8'h00);
        repeat (LOW_SAMPLES_NEEDED) send_request(OP_BATTERY, 8'h00, 8'd0);
        send_request(OP_TICK, 8'h00, 8'h00);

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            calm = 1'b0;
            case (phase)
                0: apply_setting(8'd190, 8'd94, 8'd125, 1'b0, 8'd90);
                1: apply_setting(8'd255, 8'd0, 8'd255, 1'b1, 8'd0);
                2: apply_setting(8'd0, 8'd255, 8'd0, 1'b0, 8'd255);
                3: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255)));
                4:
                begin
                    short_thr = 8'($urandom_range(128, 255));
                    apply_setting(short_thr, 8'($urandom_range(0, int'(short_thr))),
                                  8'($urandom_range(100, 200)), 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 15)));
                end
                default: apply_setting(8'd128, 8'd64, 8'd128, 1'b1, 8'd5);
            endcase
            run_random(RANDOM_ITEMS / PHASES);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests: %0d on, %0d tick, %0d batt, %0d other; %0d settings.",
                 sent[0] + sent[1] + sent[2] + sent[3], sent[OP_POWER_ON], sent[OP_TICK],
                 sent[OP_BATTERY], sent[OP_UNUSED], settings_used);
        $display("Checked %0d results, %0d of them low-battery shutdowns; %0d failures.",
                 checked, shutdowns, failures);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/fmc_pkg.sv
sv/fmc_if.sv
sv/fmc_cfg_regs.sv
sv/fmc_mode_core.sv
sv/flashlight_mode_controller.sv
tb/fmc_mode_checker.sv
tb/flashlight_mode_controller_tb.sv
